// File: rtl/sed_pkg.sv
// Shared types and character constants for the string escape decoder.
`timescale 1ns / 1ps

package sed_pkg;

	localparam int CharW   = 16;
	localparam int StatusW = 2;
	localparam int FifoDepth = 4;
	localparam int PtrW    = $clog2(FifoDepth);
	localparam int CountW  = $clog2(FifoDepth + 1);

	localparam logic [StatusW-1:0] ST_OK        = 2'd0;
	localparam logic [StatusW-1:0] ST_UNKNOWN   = 2'd1;
	localparam logic [StatusW-1:0] ST_END_IN_ESC = 2'd2;

	localparam logic [CharW-1:0] CH_NUL   = 16'h0000;
	localparam logic [CharW-1:0] CH_BSL   = 16'h005C;
	localparam logic [CharW-1:0] CH_N     = 16'h006E;
	localparam logic [CharW-1:0] CH_T     = 16'h0074;
	localparam logic [CharW-1:0] CH_R     = 16'h0072;
	localparam logic [CharW-1:0] CH_ZERO  = 16'h0030;
	localparam logic [CharW-1:0] CH_V     = 16'h0076;
	localparam logic [CharW-1:0] CH_A     = 16'h0061;
	localparam logic [CharW-1:0] CH_B     = 16'h0062;
	localparam logic [CharW-1:0] CH_F     = 16'h0066;
	localparam logic [CharW-1:0] CH_SQUOTE = 16'h0027;
	localparam logic [CharW-1:0] CH_DQUOTE = 16'h0022;
	localparam logic [CharW-1:0] CH_X     = 16'h0078;

	typedef enum logic [3:0] {
		MODE_NORMAL = 4'b0001,
		MODE_ESC    = 4'b0010,
		MODE_OCT    = 4'b0100,
		MODE_HEX    = 4'b1000
	} mode_t;

	typedef struct packed {
		logic [CharW-1:0]   out_char;
		logic [StatusW-1:0] status;
		logic               last;
	} result_t;

	// Up to two results per decoded character, in order r0 then r1.
	typedef struct packed {
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
	} dec_t;

endpackage

// File: rtl/sed_decode.sv
// Escape decoding logic with the mode and accumulator registers.
`timescale 1ns / 1ps

module sed_decode (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     fire,
	input  logic [sed_pkg::CharW-1:0] char_code,
	output sed_pkg::dec_t            dec
);
	import sed_pkg::*;

	mode_t            mode_q, mode_d;
	logic [CharW-1:0] accum_q, accum_d;
	logic             is_hex;
	logic [3:0]       hex_digit;
	logic             norm_emit;
	result_t          norm_res;
	mode_t            norm_mode;

	always_comb begin
		is_hex    = 1'b1;
		hex_digit = char_code[3:0];
		case (char_code) inside
			[16'h0030:16'h0039]: hex_digit = char_code[3:0];
			[16'h0041:16'h0046], [16'h0061:16'h0066]: hex_digit = char_code[3:0] + 4'd9;
			default: is_hex = 1'b0;
		endcase
	end

	// Handling of a character in normal mode, also used after a numeric escape ends.
	always_comb begin
		norm_emit = 1'b1;
		norm_mode = MODE_NORMAL;
		norm_res  = '{out_char: char_code, status: ST_OK, last: 1'b0};
		if (char_code == CH_BSL) begin
			norm_emit = 1'b0;
			norm_mode = MODE_ESC;
		end else if (char_code == CH_NUL) begin
			norm_res.last = 1'b1;
		end
	end

	always_comb begin
		mode_d  = mode_q;
		accum_d = accum_q;
		dec.count = 2'd0;
		dec.r0    = '{out_char: CH_NUL, status: ST_OK, last: 1'b0};
		dec.r1    = norm_res;
		case (mode_q)
			MODE_ESC: begin
				mode_d    = MODE_NORMAL;
				dec.count = 2'd1;
				case (char_code)
					CH_N:      dec.r0.out_char = 16'd10;
					CH_T:      dec.r0.out_char = 16'd9;
					CH_R:      dec.r0.out_char = 16'd13;
					CH_ZERO:   dec.r0.out_char = 16'd0;
					CH_V:      dec.r0.out_char = 16'd11;
					CH_A:      dec.r0.out_char = 16'd7;
					CH_B:      dec.r0.out_char = 16'd8;
					CH_F:      dec.r0.out_char = 16'd12;
					CH_SQUOTE: dec.r0.out_char = 16'd39;
					CH_DQUOTE: dec.r0.out_char = 16'd34;
					CH_BSL:    dec.r0.out_char = 16'd92;
					CH_X: begin
						dec.count = 2'd0;
						mode_d    = MODE_HEX;
						accum_d   = '0;
					end
					CH_NUL: begin
						dec.r0.status = ST_END_IN_ESC;
						dec.r0.last   = 1'b1;
					end
					default: begin
						if (char_code inside {[16'h0031:16'h0037]}) begin
							dec.count = 2'd0;
							mode_d    = MODE_OCT;
							accum_d   = {{(CharW-3){1'b0}}, char_code[2:0]};
						end else begin
							dec.r0.status = ST_UNKNOWN;
							dec.r0.last   = 1'b1;
						end
					end
				endcase
			end
			MODE_OCT, MODE_HEX: begin
				if (mode_q == MODE_OCT && char_code inside {[16'h0030:16'h0037]}) begin
					accum_d = {accum_q[CharW-4:0], char_code[2:0]};
				end else if (mode_q == MODE_HEX && is_hex) begin
					accum_d = {accum_q[CharW-5:0], hex_digit};
				end else begin
					// The pending value goes first, then the ending character as normal.
					dec.r0.out_char = accum_q;
					dec.count       = norm_emit ? 2'd2 : 2'd1;
					mode_d          = norm_mode;
				end
			end
			default: begin
				dec.r0    = norm_res;
				dec.count = norm_emit ? 2'd1 : 2'd0;
				mode_d    = norm_mode;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_NORMAL;
			accum_q <= '0;
		end else if (fire) begin
			mode_q  <= mode_d;
			accum_q <= accum_d;
		end
	end

endmodule

// File: rtl/sed_result_fifo.sv
// Small result queue that takes up to two results a cycle and gives one.
`timescale 1ns / 1ps

module sed_result_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  sed_pkg::dec_t    dec,
	output logic             room,
	output logic             res_valid,
	input  logic             res_stall,
	output sed_pkg::result_t res
);
	import sed_pkg::*;

	result_t           fifo_q [FifoDepth];
	logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CountW-1:0] count_q;
	logic [1:0]        n_push;
	logic              pop;

	assign n_push    = push ? dec.count : 2'd0;
	assign pop       = res_valid && !res_stall;
	assign res_valid = (count_q != '0);
	assign res       = fifo_q[rd_ptr_q];
	// Two free entries are needed before a character may be decoded.
	assign room      = (count_q <= CountW'(FifoDepth - 2));

	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			fifo_q[wr_ptr_q] <= dec.r0;
		end
		if (n_push == 2'd2) begin
			fifo_q[wr_ptr_q + PtrW'(1)] <= dec.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PtrW'(n_push);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PtrW'(1);
			end
			count_q <= count_q + CountW'(n_push) - CountW'(pop);
		end
	end

endmodule

// File: rtl/string_escape_decoder_unit.sv
// Top level of the string escape decoder.
// A character is held in the input register, then decoded into the result queue once the
// queue has room; its first result is offered from the queue.
// Throughput: one character per cycle while the result queue has room; a character that gives
// two results takes an extra output slot, absorbed by a four-entry result queue.
// Reset (arst_n low, asynchronous): normal mode, accumulator zero, queue empty.
`timescale 1ns / 1ps

module string_escape_decoder_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      char_valid,
	output logic                      char_stall,
	input  logic [sed_pkg::CharW-1:0]  char_code,
	output logic                      res_valid,
	input  logic                      res_stall,
	output logic [sed_pkg::CharW-1:0]  out_char,
	output logic [sed_pkg::StatusW-1:0] status,
	output logic                      last
);
	import sed_pkg::*;

	logic             valid_s1;
	logic [CharW-1:0] char_s1;
	logic             room;
	logic             fire;
	logic             accept;
	dec_t             dec;
	result_t          res;

	assign fire       = valid_s1 && room;
	assign char_stall = valid_s1 && !room;
	assign accept     = char_valid && !char_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept || fire) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			char_s1 <= char_code;
		end
	end

	sed_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.char_code (char_s1),
		.dec       (dec)
	);

	sed_result_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fire),
		.dec       (dec),
		.room      (room),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	assign out_char = res.out_char;
	assign status   = res.status;
	assign last     = res.last;

endmodule

// File: rtl/sed_checker.sv
// Port-level checks for the string escape decoder, bound to the top level.
`timescale 1ns / 1ps

module sed_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        res_valid,
	input logic                        res_stall,
	input logic [sed_pkg::CharW-1:0]   out_char,
	input logic [sed_pkg::StatusW-1:0] status,
	input logic                        last
);
	import sed_pkg::*;

	a_res_held: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("result withdrawn while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> $stable(out_char) && $stable(status) && $stable(last))
		else $error("stalled result changed");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (status == ST_OK || status == ST_UNKNOWN || status == ST_END_IN_ESC))
		else $error("undefined status code");

	a_error_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status != ST_OK |-> last && out_char == CH_NUL)
		else $error("error result not final or not zero");

	a_term_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && last |-> out_char == CH_NUL)
		else $error("final result carries a character");

endmodule

bind string_escape_decoder_unit sed_checker u_sed_checker (.*);
